// File: design/gbrce_pkg.sv
// ----------------------------------------------------------------------------
// gbrce_pkg
// Shared types and constants for the RGB Gaussian blur with edge replication.
// ----------------------------------------------------------------------------
package gbrce_pkg;

	localparam int PIX_W      = 8;
	localparam int RGB_W      = 3 * PIX_W;
	localparam int COEF_W     = 13;
	localparam int WT_W       = 2 * COEF_W;
	localparam int ROW_W      = 13;
	localparam int MAX_HEIGHT = 4096;
	localparam int PIX_MAX    = 255;

	// register indexes on the configuration port
	localparam logic [2:0] REG_HALF   = 3'd0;
	localparam logic [2:0] REG_WIDTH  = 3'd1;
	localparam logic [2:0] REG_HEIGHT = 3'd2;
	localparam logic [2:0] REG_COEF0  = 3'd3;
	localparam logic [2:0] REG_COEF1  = 3'd4;
	localparam logic [2:0] REG_COEF2  = 3'd5;

	// control from the sequencer to the accumulator
	typedef struct packed {
		logic valid;
		logic clear;
	} gbrce_tap_t;

	// 1D weight by distance from the center
	function automatic logic [COEF_W-1:0] coef_sel(input logic [3:0] d,
		input logic [COEF_W-1:0] c0, input logic [COEF_W-1:0] c1,
		input logic [COEF_W-1:0] c2);
		logic [COEF_W-1:0] g;
		case (d)
			4'd0: g = c0;
			4'd1: g = c1;
			4'd2: g = c2;
			default: g = '0;
		endcase
		return g;
	endfunction

endpackage

// File: design/gbrce_line_ram.sv
// ----------------------------------------------------------------------------
// gbrce_line_ram
// Line store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gbrce_line_ram
	import gbrce_pkg::*;
#(
	parameter int AW    = 13,
	parameter int DEPTH = 5120
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [RGB_W-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [RGB_W-1:0] rd_data
);

	logic [RGB_W-1:0] mem [DEPTH];
	logic [RGB_W-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: design/gbrce_mac.sv
// ----------------------------------------------------------------------------
// gbrce_mac
// Per-channel weighted accumulation of window taps, with truncate and clamp.
// ----------------------------------------------------------------------------
module gbrce_mac
	import gbrce_pkg::*;
#(
	parameter int COEF_FRAC_BITS = 12,
	parameter int ACC_W          = WT_W + PIX_W + 5
) (
	input  logic             clk,
	input  gbrce_tap_t       tap,
	input  logic [RGB_W-1:0] pixel,
	input  logic [WT_W-1:0]  wt,
	output logic [PIX_W-1:0] red,
	output logic [PIX_W-1:0] green,
	output logic [PIX_W-1:0] blue
);

	localparam int SHIFT = 2 * COEF_FRAC_BITS;

	logic [ACC_W-1:0] acc_r_q, acc_g_q, acc_b_q;

	function automatic logic [PIX_W-1:0] finish(input logic [ACC_W-1:0] acc);
		logic [ACC_W-1:0] v;
		v = acc >> SHIFT;
		return (v > ACC_W'(PIX_MAX)) ? PIX_W'(PIX_MAX) : v[PIX_W-1:0];
	endfunction

	// accumulate one tap per cycle
	always_ff @(posedge clk) begin
		if (tap.clear) begin
			acc_r_q <= '0;
			acc_g_q <= '0;
			acc_b_q <= '0;
		end else if (tap.valid) begin
			acc_r_q <= acc_r_q + ACC_W'(pixel[3*PIX_W-1:2*PIX_W] * wt);
			acc_g_q <= acc_g_q + ACC_W'(pixel[2*PIX_W-1:PIX_W] * wt);
			acc_b_q <= acc_b_q + ACC_W'(pixel[PIX_W-1:0] * wt);
		end
	end

	assign red   = finish(acc_r_q);
	assign green = finish(acc_g_q);
	assign blue  = finish(acc_b_q);

endmodule

// File: design/gaussian_blur_rgb_clamp_edge_unit.sv
// ----------------------------------------------------------------------------
// gaussian_blur_rgb_clamp_edge_unit
// Streaming RGB Gaussian blur with replicated borders over a padded raster.
// ----------------------------------------------------------------------------
// A word that yields no pixel is taken while idle; one that yields a pixel
// stalls the input through the run, drain and finish states, one line store
// read per tap through a single port. The filtered word is loaded into the
// output register from the finish state, which waits while the output stalls.
// Reset clears the registers to their defaults and the raster position to
// zero; the line store is not cleared and is only read where written.
module gaussian_blur_rgb_clamp_edge_unit
	import gbrce_pkg::*;
#(
	parameter int MAX_WIDTH      = 1024,
	parameter int MAX_HALF       = 2,
	parameter int COEF_FRAC_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_red,
	input  logic [7:0]  in_green,
	input  logic [7:0]  in_blue,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [11:0] out_row,
	output logic [9:0]  out_col,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	output logic        last_of_frame
);

	localparam int STORE_ROWS = 2 * MAX_HALF + 1;
	localparam int SLW        = $clog2(STORE_ROWS);
	localparam int CW         = $clog2(MAX_WIDTH);
	localparam int CNT_W      = $clog2(MAX_WIDTH + MAX_HALF + 1);
	localparam int TW         = $clog2(2 * MAX_HALF + 2);
	localparam int AW         = SLW + CW;
	localparam int DEPTH      = STORE_ROWS << CW;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_FIN   = 4'b1000
	} state_t;

	state_t state_q;

	logic [1:0]        half_q;
	logic [10:0]       width_q;
	logic [12:0]       height_q;
	logic [COEF_W-1:0] coef0_q, coef1_q, coef2_q;

	// configuration writes
	logic       cfg_wr;
	logic [2:0] cfg_idx;
	logic       cfg_hit;
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = paddr[4:2];
	assign cfg_hit = cfg_wr & (cfg_idx <= REG_COEF2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q   <= 2'd2;
			width_q  <= 11'd1024;
			height_q <= 13'd4096;
			coef0_q  <= 13'd1649;
			coef1_q  <= 13'd1000;
			coef2_q  <= 13'd223;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_HALF:   half_q   <= pwdata[1:0];
				REG_WIDTH:  width_q  <= pwdata[10:0];
				REG_HEIGHT: height_q <= pwdata[12:0];
				REG_COEF0:  coef0_q  <= pwdata[COEF_W-1:0];
				REG_COEF1:  coef1_q  <= pwdata[COEF_W-1:0];
				REG_COEF2:  coef2_q  <= pwdata[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (cfg_idx)
			REG_HALF:   prdata = {30'd0, half_q};
			REG_WIDTH:  prdata = {21'd0, width_q};
			REG_HEIGHT: prdata = {19'd0, height_q};
			REG_COEF0:  prdata = {19'd0, coef0_q};
			REG_COEF1:  prdata = {19'd0, coef1_q};
			REG_COEF2:  prdata = {19'd0, coef2_q};
			default:    prdata = '0;
		endcase
	end

	// effective sizes
	logic [TW-1:0]    eh;
	logic [CNT_W-1:0] ew;
	logic [ROW_W-1:0] eht;
	always_comb begin
		eh = (32'(half_q) > MAX_HALF) ? TW'(MAX_HALF) : TW'(half_q);
		if (width_q == '0) begin
			ew = CNT_W'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			ew = CNT_W'(MAX_WIDTH);
		end else begin
			ew = CNT_W'(width_q);
		end
		if (height_q == '0) begin
			eht = ROW_W'(1);
		end else if (32'(height_q) > MAX_HEIGHT) begin
			eht = ROW_W'(MAX_HEIGHT);
		end else begin
			eht = height_q;
		end
	end

	// raster position of the next word
	logic [ROW_W-1:0] r_q;
	logic [CNT_W-1:0] c_q;
	logic [SLW-1:0]   slot_q;
	logic             accept;
	logic             in_image, emit, is_last;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid & ~in_stall;
	assign in_image = (r_q < eht) && (c_q < ew);
	assign emit     = (r_q >= ROW_W'(eh)) && (c_q >= CNT_W'(eh));
	assign is_last  = (r_q == eht + ROW_W'(eh) - ROW_W'(1))
		&& (c_q == ew + CNT_W'(eh) - CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q    <= '0;
			c_q    <= '0;
			slot_q <= '0;
		end else if (cfg_hit) begin
			r_q    <= '0;
			c_q    <= '0;
			slot_q <= '0;
		end else if (accept) begin
			if (c_q + CNT_W'(1) >= ew + CNT_W'(eh)) begin
				c_q <= '0;
				if (r_q + ROW_W'(1) >= eht + ROW_W'(eh)) begin
					r_q    <= '0;
					slot_q <= '0;
				end else begin
					r_q    <= r_q + ROW_W'(1);
					slot_q <= (slot_q == SLW'(STORE_ROWS - 1)) ? '0 : slot_q + SLW'(1);
				end
			end else begin
				c_q <= c_q + CNT_W'(1);
			end
		end
	end

	// position of the word being filtered
	logic [ROW_W-1:0] r_s1;
	logic [CNT_W-1:0] c_s1;
	logic [SLW-1:0]   slot_s1;
	logic             last_s1;
	always_ff @(posedge clk) begin
		if (accept) begin
			r_s1    <= r_q;
			c_s1    <= c_q;
			slot_s1 <= slot_q;
			last_s1 <= is_last;
		end
	end

	// tap counters
	logic [TW-1:0] iy_q, ix_q;
	logic [TW-1:0] span;
	logic          last_tap;
	assign span     = {eh[TW-2:0], 1'b0};
	assign last_tap = (iy_q == span) && (ix_q == span);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iy_q    <= '0;
			ix_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					iy_q <= '0;
					ix_q <= '0;
					if (accept && emit) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (last_tap) begin
						state_q <= ST_DRAIN;
					end else if (ix_q == span) begin
						ix_q <= '0;
						iy_q <= iy_q + TW'(1);
					end else begin
						ix_q <= ix_q + TW'(1);
					end
				end
				ST_DRAIN: state_q <= ST_FIN;
				ST_FIN: begin
					if (!out_valid || !out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// source row with edge replication, mapped to its store slot
	logic signed [ROW_W+1:0]  rs;
	logic [ROW_W-1:0]         sr;
	logic [TW-1:0]            rd_back;
	logic [SLW-1:0]           rslot;
	logic signed [CNT_W+1:0]  cs;
	logic [CNT_W-1:0]         sc;
	logic [3:0]               ady, adx;
	always_comb begin
		rs = $signed({2'b00, r_s1}) - $signed((ROW_W+2)'(span))
			+ $signed((ROW_W+2)'(iy_q));
		if (rs < 0) begin
			sr = '0;
		end else if (rs > $signed({2'b00, eht - ROW_W'(1)})) begin
			sr = eht - ROW_W'(1);
		end else begin
			sr = rs[ROW_W-1:0];
		end
		rd_back = TW'(r_s1 - sr);
		if (32'(slot_s1) >= 32'(rd_back)) begin
			rslot = slot_s1 - SLW'(rd_back);
		end else begin
			rslot = SLW'(32'(slot_s1) + STORE_ROWS - 32'(rd_back));
		end
		cs = $signed({2'b00, c_s1}) - $signed((CNT_W+2)'(span))
			+ $signed((CNT_W+2)'(ix_q));
		if (cs < 0) begin
			sc = '0;
		end else if (cs > $signed({2'b00, ew - CNT_W'(1)})) begin
			sc = ew - CNT_W'(1);
		end else begin
			sc = cs[CNT_W-1:0];
		end
		ady = (iy_q >= eh) ? 4'(iy_q - eh) : 4'(eh - iy_q);
		adx = (ix_q >= eh) ? 4'(ix_q - eh) : 4'(eh - ix_q);
	end

	// tap weight, aligned with the read data
	logic [WT_W-1:0] wt_s1;
	gbrce_tap_t      tap;
	logic            tap_v_s1;
	always_ff @(posedge clk) begin
		wt_s1 <= WT_W'(coef_sel(ady, coef0_q, coef1_q, coef2_q)
			* coef_sel(adx, coef0_q, coef1_q, coef2_q));
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_v_s1 <= 1'b0;
		end else begin
			tap_v_s1 <= (state_q == ST_RUN);
		end
	end
	assign tap.valid = tap_v_s1;
	assign tap.clear = accept;

	// line store
	logic [RGB_W-1:0] rd_pix;
	gbrce_line_ram #(
		.AW    (AW),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (accept & in_image),
		.wr_addr ({slot_q, c_q[CW-1:0]}),
		.wr_data ({in_red, in_green, in_blue}),
		.rd_en   (state_q == ST_RUN),
		.rd_addr ({rslot, sc[CW-1:0]}),
		.rd_data (rd_pix)
	);

	// accumulator sized for every tap of the largest kernel
	logic [PIX_W-1:0] f_red, f_green, f_blue;
	gbrce_mac #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS),
		.ACC_W          (WT_W + PIX_W + $clog2(STORE_ROWS * STORE_ROWS))
	) u_mac (
		.clk   (clk),
		.tap   (tap),
		.pixel (rd_pix),
		.wt    (wt_s1),
		.red   (f_red),
		.green (f_green),
		.blue  (f_blue)
	);

	// output word register
	logic out_valid_q;
	logic load;
	assign load = (state_q == ST_FIN) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	logic [ROW_W-1:0] orow;
	logic [CNT_W-1:0] ocol;
	assign orow = r_s1 - ROW_W'(eh);
	assign ocol = c_s1 - CNT_W'(eh);

	always_ff @(posedge clk) begin
		if (load) begin
			out_row       <= orow[11:0];
			out_col       <= ocol[9:0];
			out_red       <= f_red;
			out_green     <= f_green;
			out_blue      <= f_blue;
			last_of_frame <= last_s1;
		end
	end

	assign out_valid = out_valid_q;

endmodule
